[design/rsb_pkg.sv]
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared types and constants of the run-length sprite blitter.
// ----------------------------------------------------------------------------
package rsb_pkg;

  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 3;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ROW_PITCH     = 3'd0,
    CFG_SPRITE_WIDTH  = 3'd1,
    CFG_SPRITE_HEIGHT = 3'd2,
    CFG_POS_X         = 3'd3,
    CFG_POS_Y         = 3'd4,
    CFG_FLASH_COLOR   = 3'd5,
    CFG_MODE_FLAGS    = 3'd6
  } cfg_index_t;

  // operation codes of an input item
  localparam logic OP_START  = 1'b0;
  localparam logic OP_STREAM = 1'b1;

  // stream byte codes
  localparam logic [7:0] CODE_ROW_END = 8'd0;
  localparam logic [7:0] CODE_SKIP    = 8'd1;

  // mode flag bits
  localparam int MODE_MIRROR    = 0;
  localparam int MODE_BLINK     = 1;
  localparam int MODE_NO_MASK   = 2;
  localparam int MODE_INVISIBLE = 3;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  typedef struct packed {
    logic       operation;
    logic [7:0] code_byte;
    logic [7:0] mask_value;
  } rsb_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_color;
    logic        end_of_row;
    logic        last;
  } rsb_out_t;

  typedef struct packed {
    logic [9:0]  row_pitch;
    logic [7:0]  sprite_width;
    logic [7:0]  sprite_height;
    logic [10:0] pos_x;
    logic [9:0]  pos_y;
    logic [7:0]  flash_color;
    logic [3:0]  mode_flags;
  } rsb_cfg_t;

  // what the front has made of one item
  typedef enum logic [2:0] {
    KIND_START,
    KIND_MARKER,
    KIND_COUNT,
    KIND_ROW_END,
    KIND_PIXEL
  } rsb_kind_t;

  typedef struct packed {
    rsb_kind_t  kind;
    logic [7:0] code_byte;
    logic [7:0] mask_value;
  } rsb_item_t;

endpackage

[design/rsb_front.sv]
// ----------------------------------------------------------------------------
// rsb_front
// Accepts input items and classifies each stream byte by its code and by
// whether a skip marker came just before it.
// ----------------------------------------------------------------------------
module rsb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rsb_pkg::rsb_in_t   in_data,
  output logic               push,
  output rsb_pkg::rsb_item_t push_item,
  input  logic               queue_full
);
  import rsb_pkg::*;

  logic      expect_r;
  logic      expect_nxt;
  rsb_kind_t kind;
  logic      take;

  assign in_stall = queue_full;
  assign take     = in_valid && !queue_full;
  assign push     = take;

  always_comb begin
    expect_nxt = expect_r;
    kind       = KIND_PIXEL;
    if (in_data.operation == OP_START) begin
      kind       = KIND_START;
      expect_nxt = 1'b0;
    end else if (expect_r) begin
      // byte after a marker is a count whatever its value
      kind       = KIND_COUNT;
      expect_nxt = 1'b0;
    end else if (in_data.code_byte == CODE_SKIP) begin
      kind       = KIND_MARKER;
      expect_nxt = 1'b1;
    end else if (in_data.code_byte == CODE_ROW_END) begin
      kind       = KIND_ROW_END;
    end
  end

  assign push_item = '{kind: kind, code_byte: in_data.code_byte,
                       mask_value: in_data.mask_value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= 1'b0;
    end else if (take) begin
      expect_r <= expect_nxt;
    end
  end

endmodule

[design/rsb_queue.sv]
// ----------------------------------------------------------------------------
// rsb_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rsb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rsb_pkg::rsb_item_t push_item,
  output logic               full,
  output logic               pop_valid,
  output rsb_pkg::rsb_item_t pop_item,
  input  logic               pop
);
  import rsb_pkg::*;

  rsb_item_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;
  logic [QCNT_BITS-1:0] count_nxt;

  assign full      = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("pointers disagree with empty count");

endmodule

[design/rsb_back.sv]
// ----------------------------------------------------------------------------
// rsb_back
// Carries out classified items: address and clip set-up on start, pixel
// writes, skips and row ends, with a registered result stage.
// ----------------------------------------------------------------------------
module rsb_back #(
  parameter int ADDR_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rsb_pkg::rsb_cfg_t  cfg,
  input  logic               item_valid,
  input  rsb_pkg::rsb_item_t item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rsb_pkg::rsb_out_t  out_data
);
  import rsb_pkg::*;

  logic [ADDR_BITS-1:0] dest_r, dest_nxt;
  logic [10:0]          col_r, col_nxt;
  logic [8:0]           clip_right_r, clip_right_nxt;
  logic [8:0]           clip_left_r, clip_left_nxt;
  logic [7:0]           rows_r, rows_nxt;
  logic                 out_valid_r;
  rsb_out_t             out_data_r, out_data_nxt;

  logic                 mirrored;
  logic [10:0]          col_reload;
  logic signed [12:0]   px;
  logic signed [12:0]   w13;
  logic signed [12:0]   sw13;
  logic signed [12:0]   right_edge;
  logic signed [12:0]   r13;
  logic signed [12:0]   neg_px;
  logic [19:0]          row_base;
  logic signed [31:0]   base32;
  logic signed [11:0]   col_s;
  logic                 hide;
  logic                 mask_ok;
  logic [31:0]          addr_ext;
  logic                 can_take;

  assign mirrored   = cfg.mode_flags[MODE_MIRROR];
  assign col_reload = mirrored ? ({3'b000, cfg.sprite_width} - 11'd1) : 11'd0;
  assign can_take   = !out_valid_r || !out_stall;
  assign pop        = item_valid && can_take;

  // start set-up
  assign px         = {{2{cfg.pos_x[10]}}, cfg.pos_x};
  assign w13        = {5'b00000, cfg.sprite_width};
  assign sw13       = {3'b000, cfg.row_pitch};
  assign right_edge = px + w13;
  assign neg_px     = -px;
  assign row_base   = cfg.pos_y * cfg.row_pitch;
  assign base32     = $signed({12'd0, row_base}) + 32'(px)
                    + (mirrored ? (32'(w13) - 32'sd1) : 32'sd0);

  always_comb begin
    r13 = (right_edge > sw13) ? (sw13 - px) : w13;
    if (r13 < 0) begin
      r13 = '0;
    end
  end

  // clip window test on the signed column
  assign col_s   = {col_r[10], col_r};
  assign hide    = (col_s >= $signed({3'b000, clip_right_r}))
                || (col_s < $signed({3'b000, clip_left_r}));
  assign mask_ok = (item.mask_value == 8'd0) || cfg.mode_flags[MODE_NO_MASK];
  assign addr_ext = 32'(dest_r);

  always_comb begin
    dest_nxt       = dest_r;
    col_nxt        = col_r;
    clip_right_nxt = clip_right_r;
    clip_left_nxt  = clip_left_r;
    rows_nxt       = rows_r;
    out_data_nxt   = '{write_enable: 1'b0, write_address: addr_ext[15:0],
                       write_color: 8'd0, end_of_row: 1'b0, last: 1'b0};
    unique case (item.kind)
      KIND_START: begin
        dest_nxt       = base32[ADDR_BITS-1:0];
        clip_right_nxt = r13[8:0];
        clip_left_nxt  = (px < 0) ? neg_px[8:0] : 9'd0;
        col_nxt        = col_reload;
        rows_nxt       = 8'd0;
      end
      KIND_MARKER: begin
      end
      KIND_COUNT: begin
        if (mirrored) begin
          dest_nxt = dest_r - ADDR_BITS'(item.code_byte);
          col_nxt  = col_r - {3'b000, item.code_byte};
        end else begin
          dest_nxt = dest_r + ADDR_BITS'(item.code_byte);
          col_nxt  = col_r + {3'b000, item.code_byte};
        end
      end
      KIND_ROW_END: begin
        if (mirrored) begin
          dest_nxt = dest_r + ADDR_BITS'(cfg.row_pitch)
                   + ADDR_BITS'(cfg.sprite_width);
        end else begin
          dest_nxt = dest_r + ADDR_BITS'(cfg.row_pitch)
                   - ADDR_BITS'(cfg.sprite_width);
        end
        col_nxt = col_reload;
        out_data_nxt.end_of_row = 1'b1;
        if (rows_r != 8'hFF) begin
          rows_nxt = rows_r + 8'd1;
          out_data_nxt.last = ((rows_r + 8'd1) == cfg.sprite_height);
        end
      end
      KIND_PIXEL: begin
        if (mask_ok && !cfg.mode_flags[MODE_INVISIBLE] && !hide) begin
          out_data_nxt.write_enable = 1'b1;
          out_data_nxt.write_color  = cfg.mode_flags[MODE_BLINK] ? cfg.flash_color
                                                                 : item.code_byte;
        end
        if (mirrored) begin
          dest_nxt = dest_r - 1'b1;
          col_nxt  = col_r - 11'd1;
        end else begin
          dest_nxt = dest_r + 1'b1;
          col_nxt  = col_r + 11'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r       <= '0;
      col_r        <= '0;
      clip_right_r <= '0;
      clip_left_r  <= '0;
      rows_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        dest_r       <= dest_nxt;
        col_r        <= col_nxt;
        clip_right_r <= clip_right_nxt;
        clip_left_r  <= clip_left_nxt;
        rows_r       <= rows_nxt;
        // a start item leaves no result
        out_valid_r  <= (item.kind != KIND_START);
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.kind != KIND_START) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/rle_sprite_blitter.sv]
// ----------------------------------------------------------------------------
// rle_sprite_blitter
// Run-length sprite decoder producing screen pixel writes.
// ----------------------------------------------------------------------------
// Usage: write the seven configuration registers through cfg_we, cfg_index
// and cfg_data while the block is idle. Then send a start item (operation 0)
// followed by the sprite's stream bytes (operation 1), each with the mask
// byte at the current destination. Both channels use valid and stall; a
// transfer happens when valid is high and stall is low.
// A start item sets up address and clip window and gives no result; every
// stream byte gives exactly one result with write enable, address, colour,
// end-of-row and last.
// Path: the front classifies each input transfer into a queue register, then
// the execute stage takes it from the queue into its output register, which
// drives out_valid and out_data. Throughput is one item per cycle while the
// receiver does not stall; the start set-up with its one multiply is done in
// the execute stage as well.
// When the receiver stalls the output register holds its result, the two-entry
// queue fills and then in_stall rises; nothing is lost. Reset clears the
// queue, the decoder state and the registers to their reset values.
// ----------------------------------------------------------------------------
module rle_sprite_blitter #(
  parameter int ADDR_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  rsb_pkg::rsb_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rsb_pkg::rsb_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [rsb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [rsb_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import rsb_pkg::*;

  rsb_cfg_t  cfg_r;
  logic      push;
  rsb_item_t push_item;
  logic      queue_full;
  logic      q_valid;
  rsb_item_t q_item;
  logic      pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{row_pitch: 10'd320, sprite_width: 8'd16, sprite_height: 8'd16,
                 pos_x: 11'd0, pos_y: 10'd0, flash_color: 8'd255, mode_flags: 4'd0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_PITCH:     cfg_r.row_pitch     <= cfg_data[9:0];
        CFG_SPRITE_WIDTH:  cfg_r.sprite_width  <= cfg_data[7:0];
        CFG_SPRITE_HEIGHT: cfg_r.sprite_height <= cfg_data[7:0];
        CFG_POS_X:         cfg_r.pos_x         <= cfg_data[10:0];
        CFG_POS_Y:         cfg_r.pos_y         <= cfg_data[9:0];
        CFG_FLASH_COLOR:   cfg_r.flash_color   <= cfg_data[7:0];
        CFG_MODE_FLAGS:    cfg_r.mode_flags    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  rsb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  rsb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .pop       (pop)
  );

  rsb_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item       (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[test/rle_sprite_blitter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_blitter_test
// Self-checking bench for the run-length sprite blitter. An initial block
// loads a set of registers while the block is idle, then queues start items
// and stream bytes. A clocked driver sends them and feeds each accepted
// transfer to a local model of the decoder. A clocked monitor checks every
// result against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module rle_sprite_blitter_test;
  import rsb_pkg::*;

  localparam int ITEM_TARGET  = 500;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 200;
  localparam int IDLE_NONE    = 0;
  localparam int IDLE_LIGHT   = 1;
  localparam int IDLE_HEAVY   = 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rsb_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsb_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // register copy and decoder state of the local model
  rsb_cfg_t regs_now;
  logic [15:0] pen_address;
  logic [10:0] pen_column;
  logic [8:0] clip_hi;
  logic [8:0] clip_lo;
  logic [7:0] rows_ended;
  bit count_next;

  rsb_in_t bytes_to_send[$];
  rsb_out_t writes_due[$];
  int bytes_queued = 0;
  int bytes_taken = 0;
  int mismatches = 0;
  int idle_mode = IDLE_NONE;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  int send_gap = 0;

  always #2 clk = ~clk;

  rle_sprite_blitter #(.ADDR_BITS(16)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic int pick_gap();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic bit take_break(int mode);
    case (mode)
      IDLE_LIGHT: return $urandom_range(0, 99) < 15;
      IDLE_HEAVY: return $urandom_range(0, 99) < 45;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic logic [10:0] column_start();
    return regs_now.mode_flags[MODE_MIRROR] ? 11'(regs_now.sprite_width) - 11'd1 : 11'd0;
  endfunction

  // one input item: updates the pen state, returns the result if it gives one
  task automatic blit_step(input rsb_in_t it, output bit emits, output rsb_out_t res);
    bit mirror;
    int px, w, sw, base, r, col, cl, cr;
    logic [7:0] old_rows;
    mirror = regs_now.mode_flags[MODE_MIRROR];
    res = '0;
    res.write_address = pen_address;
    emits = 1'b0;
    if (it.operation == OP_START) begin
      px = $signed(regs_now.pos_x);
      w = regs_now.sprite_width;
      sw = regs_now.row_pitch;
      base = int'(regs_now.pos_y) * sw + px + (mirror ? w - 1 : 0);
      r = (px + w > sw) ? sw - px : w;
      if (r < 0) r = 0;
      clip_hi = r[8:0];
      clip_lo = (px < 0) ? 9'(-px) : 9'd0;
      pen_address = base[15:0];
      pen_column = column_start();
      rows_ended = '0;
      count_next = 1'b0;
    end else begin
      emits = 1'b1;
      if (count_next) begin
        count_next = 1'b0;
        if (mirror) begin
          pen_address = pen_address - 16'(it.code_byte);
          pen_column = pen_column - 11'(it.code_byte);
        end else begin
          pen_address = pen_address + 16'(it.code_byte);
          pen_column = pen_column + 11'(it.code_byte);
        end
      end else if (it.code_byte == CODE_SKIP) begin
        count_next = 1'b1;
      end else if (it.code_byte == CODE_ROW_END) begin
        if (mirror)
          pen_address = pen_address + 16'(regs_now.row_pitch) + 16'(regs_now.sprite_width);
        else
          pen_address = pen_address + 16'(regs_now.row_pitch) - 16'(regs_now.sprite_width);
        pen_column = column_start();
        old_rows = rows_ended;
        if (rows_ended != 8'd255) rows_ended = rows_ended + 8'd1;
        res.end_of_row = 1'b1;
        res.last = (rows_ended != old_rows) && (rows_ended == regs_now.sprite_height);
      end else begin
        col = $signed(pen_column);
        cl = clip_lo;
        cr = clip_hi;
        if ((it.mask_value == 8'd0 || regs_now.mode_flags[MODE_NO_MASK]) &&
            !regs_now.mode_flags[MODE_INVISIBLE] && col < cr && col >= cl) begin
          res.write_enable = 1'b1;
          res.write_color = regs_now.mode_flags[MODE_BLINK] ? regs_now.flash_color
                                                            : it.code_byte;
        end
        if (mirror) begin
          pen_address = pen_address - 16'd1;
          pen_column = pen_column - 11'd1;
        end else begin
          pen_address = pen_address + 16'd1;
          pen_column = pen_column + 11'd1;
        end
      end
    end
  endtask

  always @(posedge clk) begin : drive_in
    bit emits;
    rsb_out_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        blit_step(in_data, emits, res);
        if (emits) writes_due.push_back(res);
        bytes_taken++;
      end
      if ((in_valid && !in_stall) || !in_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (bytes_to_send.size() > 0) begin
          in_data <= bytes_to_send.pop_front();
          in_valid <= 1'b1;
          send_gap <= take_break(idle_mode) ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_out
    rsb_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (writes_due.size() == 0) begin
          $error("unexpected result: %p", out_data);
          mismatches++;
        end else begin
          want = writes_due.pop_front();
          if (out_data.write_enable !== want.write_enable) begin
            $error("write_enable: expected %0d, got %0d", want.write_enable,
                   out_data.write_enable);
            mismatches++;
          end
          if (out_data.write_address !== want.write_address) begin
            $error("write_address: expected %h, got %h", want.write_address,
                   out_data.write_address);
            mismatches++;
          end
          if (out_data.write_color !== want.write_color) begin
            $error("write_color: expected %h, got %h", want.write_color, out_data.write_color);
            mismatches++;
          end
          if (out_data.end_of_row !== want.end_of_row) begin
            $error("end_of_row: expected %0d, got %0d", want.end_of_row, out_data.end_of_row);
            mismatches++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data.last);
            mismatches++;
          end
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (take_break(idle_mode)) begin
        stall_left <= pick_gap() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_item(logic op, logic [7:0] code, logic [7:0] mask);
    rsb_in_t it;
    it.operation = op;
    it.code_byte = code;
    it.mask_value = mask;
    bytes_to_send.push_back(it);
    bytes_queued++;
  endtask

  function automatic logic [7:0] pick_mask();
    return $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
  endfunction

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ROW_PITCH:     regs_now.row_pitch = val[9:0];
      CFG_SPRITE_WIDTH:  regs_now.sprite_width = val[7:0];
      CFG_SPRITE_HEIGHT: regs_now.sprite_height = val[7:0];
      CFG_POS_X:         regs_now.pos_x = val;
      CFG_POS_Y:         regs_now.pos_y = val[9:0];
      CFG_FLASH_COLOR:   regs_now.flash_color = val[7:0];
      CFG_MODE_FLAGS:    regs_now.mode_flags = val[3:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(rsb_cfg_t s);
    cfg_write(CFG_ROW_PITCH, 11'(s.row_pitch));
    cfg_write(CFG_SPRITE_WIDTH, 11'(s.sprite_width));
    cfg_write(CFG_SPRITE_HEIGHT, 11'(s.sprite_height));
    cfg_write(CFG_POS_X, s.pos_x);
    cfg_write(CFG_POS_Y, 11'(s.pos_y));
    cfg_write(CFG_FLASH_COLOR, 11'(s.flash_color));
    cfg_write(CFG_MODE_FLAGS, 11'(s.mode_flags));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic rsb_cfg_t pick_settings(int k);
    rsb_cfg_t s;
    int px;
    s.row_pitch = ($urandom_range(0, 3) == 0) ?
                  ($urandom_range(0, 1) ? 10'd1 : 10'd1023) : 10'($urandom_range(16, 1023));
    s.sprite_width = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(1, 12));
    s.sprite_height = 8'($urandom_range(1, 4));
    case ($urandom_range(0, 3))
      0: px = int'($urandom_range(0, 300)) - 256;
      1: px = int'(s.row_pitch) - int'(s.sprite_width) + int'($urandom_range(0, 8)) - 4;
      default: px = int'($urandom_range(0, 1279)) - 256;
    endcase
    if (px < -256) px = -256;
    if (px > 1023) px = 1023;
    s.pos_x = 11'(px);
    s.pos_y = 10'($urandom_range(0, 1023));
    s.flash_color = 8'($urandom);
    s.mode_flags = 4'($urandom);
    case (k)
      0: begin
        s = '0;
        s.row_pitch = 10'd1;
        s.sprite_width = 8'd1;
        s.sprite_height = 8'd1;
        s.pos_x = -11'sd256;
      end
      1: begin
        // tall sprite: rows counter runs up to its ceiling
        s.row_pitch = 10'd1023;
        s.sprite_width = 8'd255;
        s.sprite_height = 8'd255;
        s.pos_x = 11'd1023;
        s.pos_y = 10'd1023;
        s.flash_color = 8'd255;
      end
      2: s.mode_flags = 4'hF;
      default: ;
    endcase
    return s;
  endfunction

  // start item, then rows of colours and skips, each closed by a row end
  task automatic queue_sprite(int rows, int max_px);
    int n;
    push_item(OP_START, 8'($urandom), 8'($urandom));
    for (int r = 0; r < rows; r++) begin
      n = $urandom_range(0, max_px);
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(0, 5) == 0) begin
          push_item(OP_STREAM, CODE_SKIP, pick_mask());
          push_item(OP_STREAM, $urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom),
                    pick_mask());
        end else begin
          push_item(OP_STREAM, 8'($urandom_range(2, 255)), pick_mask());
        end
      end
      push_item(OP_STREAM, CODE_ROW_END, pick_mask());
    end
  endtask

  initial begin : stimulus
    int k;
    int rows;
    rsb_cfg_t s;
    regs_now = '0;
    regs_now.row_pitch = 10'd320;
    regs_now.sprite_width = 8'd16;
    regs_now.sprite_height = 8'd16;
    regs_now.flash_color = 8'd255;
    pen_address = '0;
    pen_column = '0;
    clip_hi = '0;
    clip_lo = '0;
    rows_ended = '0;
    count_next = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stream before any start, then the special codes at reset settings
    idle_mode = IDLE_LIGHT;
    push_item(OP_STREAM, 8'h55, 8'h00);
    push_item(OP_STREAM, CODE_ROW_END, 8'h00);
    push_item(OP_START, 8'hFF, 8'hFF);
    push_item(OP_STREAM, 8'd2, 8'h00);
    push_item(OP_STREAM, 8'd255, 8'h00);
    push_item(OP_STREAM, 8'h80, 8'hFF);
    push_item(OP_STREAM, 8'h7F, 8'h01);
    push_item(OP_STREAM, CODE_SKIP, 8'h00);
    push_item(OP_STREAM, 8'd0, 8'h00);
    push_item(OP_STREAM, CODE_SKIP, 8'hAA);
    push_item(OP_STREAM, CODE_SKIP, 8'h00);
    push_item(OP_STREAM, 8'hAA, 8'h00);
    push_item(OP_STREAM, CODE_ROW_END, 8'h00);
    push_item(OP_STREAM, CODE_SKIP, 8'h00);
    push_item(OP_STREAM, 8'd255, 8'h00);
    push_item(OP_STREAM, 8'd3, 8'h00);
    push_item(OP_START, 8'h00, 8'h00);
    push_item(OP_STREAM, 8'h5A, 8'h00);
    push_item(OP_STREAM, CODE_ROW_END, 8'h00);
    wait_drained();

    k = 0;
    while (k < 4 || bytes_queued < ITEM_TARGET) begin
      s = pick_settings(k);
      load_settings(s);
      idle_mode = (k == 3) ? IDLE_NONE : k % 3;
      if (k == 3) hold_req++;
      case (k)
        0: queue_sprite(3, 4);
        1: queue_sprite(258, 1);
        3: queue_sprite(10, 6);
        default: begin
          rows = int'(s.sprite_height) + int'($urandom_range(0, 2)) - 1;
          queue_sprite(rows, 6);
        end
      endcase
      // noise and broken sequences
      repeat ($urandom_range(0, 3))
        push_item(1'($urandom), 8'($urandom), 8'($urandom));
      wait_drained();
      k++;
    end

    if (mismatches == 0)
      $display("PASS rle_sprite_blitter");
    else
      $display("FAIL rle_sprite_blitter");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL rle_sprite_blitter");
    $finish;
  end

endmodule

[rle_sprite_blitter.f]
design/rsb_pkg.sv
design/rsb_front.sv
design/rsb_queue.sv
design/rsb_back.sv
design/rle_sprite_blitter.sv
test/rle_sprite_blitter_test.sv
